>>> rtl/wth_pkg.sv
// ----------------------------------------------------------------------------
// wth_pkg
// Shared types and constants of the window table hit test block: action
// codes, sequencer states and the request and response beats.
// ----------------------------------------------------------------------------
package wth_pkg;

  localparam int MAX_WINDOWS = 8;
  localparam int ID_W        = 4;
  localparam int COORD_W     = 16;

  typedef enum logic [3:0] {
    ACT_CREATE    = 4'd0,
    ACT_DESTROY   = 4'd1,
    ACT_SHOW      = 4'd2,
    ACT_HIDE      = 4'd3,
    ACT_MOVE      = 4'd4,
    ACT_SET_LAYER = 4'd5,
    ACT_HIT_TEST  = 4'd6,
    ACT_QUERY     = 4'd7,
    ACT_TOP_LAYER = 4'd8
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [3:0]         action;
    logic [ID_W-1:0]    window_id;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] layer;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]    result_id;
    logic               success;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_width;
    logic [COORD_W-1:0] out_height;
    logic [COORD_W-1:0] out_layer;
    logic               any_visible;
  } rsp_t;

endpackage

>>> rtl/wth_req_if.sv
// ----------------------------------------------------------------------------
// wth_req_if
// Request channel: one beat carries one window table action.
// ----------------------------------------------------------------------------
interface wth_req_if;
  logic          valid;
  logic          ready;
  wth_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/wth_rsp_if.sv
// ----------------------------------------------------------------------------
// wth_rsp_if
// Response channel: one beat carries the result of one action.
// ----------------------------------------------------------------------------
interface wth_rsp_if;
  logic          valid;
  logic          ready;
  wth_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/window_table_hit_test_top.sv
// ----------------------------------------------------------------------------
// window_table_hit_test_top
// Keeps a table of MaxWindows window rectangles (valid and visible flags in
// flip-flops, position, size and layer in three small RAMs) and runs one
// action per request beat, answering with exactly one response beat. The
// block takes one action at a time and holds ready low while it works.
// Show, hide, destroy, move, set layer and unknown actions go from the
// execute step straight to done, query passes a wait step for the RAM
// read, create walks the valid flags from slot 0 to the first free slot,
// and hit test and top layer scan every entry. The scans read one entry
// per cycle through the RAM read port and a single containment and layer
// comparator. A finished response sits in an output register, so the next
// request is taken while it waits; a further result waits in the last
// sequencer step until that register is free. Reset clears the flags at
// once; no clearing pass runs.
// ----------------------------------------------------------------------------
module window_table_hit_test_top #(
  parameter int MaxWindows = wth_pkg::MAX_WINDOWS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wth_req_if.sink    req_i,
  wth_rsp_if.source  rsp_o
);
  import wth_pkg::*;

  localparam int IdxW = (MaxWindows > 1) ? $clog2(MaxWindows) : 1;
  localparam int CntW = $clog2(MaxWindows + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(MaxWindows);
  localparam int PosW = 2 * COORD_W;

  state_e                state_q, state_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [MaxWindows-1:0] valid_q, valid_d;
  logic [MaxWindows-1:0] vis_q, vis_d;
  req_t                  req_q;
  rsp_t                  res_q, res_d;
  logic [COORD_W-1:0]    best_q, best_d;
  rsp_t                  out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  accept;
  logic                  out_load;
  logic [IdxW-1:0]       slot;
  logic                  id_ok;
  logic                  zero_size;
  logic [IdxW-1:0]       idx_lo;
  logic [IdxW-1:0]       prev;
  logic                  entry_en;
  logic                  in_rect;

  logic                  pos_we, size_we, lay_we, ram_re;
  logic [IdxW-1:0]       waddr, raddr;
  logic [PosW-1:0]       pos_rd, size_rd;
  logic [COORD_W-1:0]    lay_rd;

  // ---------------------------------------------------------------------------
  // Entry storage
  // ---------------------------------------------------------------------------
  wth_ram #(.Width(PosW), .Depth(MaxWindows)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (waddr),
    .wdata_i ({req_q.pos_x, req_q.pos_y}),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (pos_rd)
  );

  wth_ram #(.Width(PosW), .Depth(MaxWindows)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (waddr),
    .wdata_i ({req_q.width, req_q.height}),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (size_rd)
  );

  wth_ram #(.Width(COORD_W), .Depth(MaxWindows)) u_lay_ram (
    .clk_i   (clk_i),
    .we_i    (lay_we),
    .waddr_i (waddr),
    .wdata_i (req_q.layer),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (lay_rd)
  );

  // ---------------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------------
  assign accept    = req_i.valid && req_i.ready;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);
  assign slot      = IdxW'(req_q.window_id - 4'd1);
  assign id_ok     = (req_q.window_id != '0) && (int'(req_q.window_id) <= MaxWindows)
                     && valid_q[slot];
  assign zero_size = (req_q.width == '0) || (req_q.height == '0);
  assign idx_lo    = idx_q[IdxW-1:0];
  assign prev      = IdxW'(idx_q - CntW'(1));
  assign entry_en  = valid_q[prev] && vis_q[prev];

  // shared comparator: point against the rectangle read last cycle
  assign in_rect = (req_q.pos_x >= pos_rd[PosW-1:COORD_W])
                && ({1'b0, req_q.pos_x} <
                    ({1'b0, pos_rd[PosW-1:COORD_W]} + {1'b0, size_rd[PosW-1:COORD_W]}))
                && (req_q.pos_y >= pos_rd[COORD_W-1:0])
                && ({1'b0, req_q.pos_y} <
                    ({1'b0, pos_rd[COORD_W-1:0]} + {1'b0, size_rd[COORD_W-1:0]}));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (req_q.action)
          ACT_CREATE:    state_d = zero_size ? ST_DONE : ST_SCAN;
          ACT_HIT_TEST,
          ACT_TOP_LAYER: state_d = ST_SCAN;
          ACT_QUERY:     state_d = id_ok ? ST_WAIT : ST_DONE;
          default:       state_d = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (req_q.action == ACT_CREATE) begin
          if (!valid_q[idx_lo] || (idx_q == LastCnt - CntW'(1))) state_d = ST_DONE;
        end else if (idx_q == LastCnt) begin
          state_d = ST_DONE;
        end
      end
      ST_WAIT: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath control
  // ---------------------------------------------------------------------------
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    vis_d   = vis_q;
    res_d   = res_q;
    best_d  = best_q;
    pos_we  = 1'b0;
    size_we = 1'b0;
    lay_we  = 1'b0;
    ram_re  = 1'b0;
    waddr   = slot;
    raddr   = slot;

    unique case (state_q)
      ST_EXEC: begin
        res_d  = '0;
        best_d = '0;
        idx_d  = '0;
        unique case (req_q.action)
          ACT_DESTROY: begin
            if (id_ok) begin
              valid_d[slot] = 1'b0;
              vis_d[slot]   = 1'b0;
              res_d.success = 1'b1;
            end
          end
          ACT_SHOW: begin
            if (id_ok) begin
              vis_d[slot]   = 1'b1;
              res_d.success = 1'b1;
            end
          end
          ACT_HIDE: begin
            if (id_ok) begin
              vis_d[slot]   = 1'b0;
              res_d.success = 1'b1;
            end
          end
          ACT_MOVE: begin
            pos_we        = id_ok;
            res_d.success = id_ok;
          end
          ACT_SET_LAYER: begin
            lay_we        = id_ok;
            res_d.success = id_ok;
          end
          ACT_QUERY: begin
            ram_re        = id_ok;
            res_d.success = id_ok;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (req_q.action == ACT_CREATE) begin
          waddr = idx_lo;
          if (!valid_q[idx_lo]) begin
            pos_we          = 1'b1;
            size_we         = 1'b1;
            lay_we          = 1'b1;
            valid_d[idx_lo] = 1'b1;
            vis_d[idx_lo]   = 1'b1;
            res_d.result_id = ID_W'(idx_q + CntW'(1));
            res_d.success   = 1'b1;
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end else begin
          // read entry idx, judge entry idx-1 whose data has just landed
          ram_re = (idx_q != LastCnt);
          raddr  = idx_lo;
          idx_d  = idx_q + CntW'(1);
          if ((idx_q != '0) && entry_en) begin
            if (req_q.action == ACT_HIT_TEST) begin
              if (in_rect && (!res_q.success || (lay_rd >= best_q))) begin
                best_d          = lay_rd;
                res_d.result_id = ID_W'(idx_q);
                res_d.success   = 1'b1;
              end
            end else if (!res_q.success || (lay_rd > res_q.out_layer)) begin
              res_d.out_layer = lay_rd;
              res_d.success   = 1'b1;
            end
          end
        end
      end
      ST_WAIT: begin
        res_d.out_x      = pos_rd[PosW-1:COORD_W];
        res_d.out_y      = pos_rd[COORD_W-1:0];
        res_d.out_width  = size_rd[PosW-1:COORD_W];
        res_d.out_height = size_rd[COORD_W-1:0];
        res_d.out_layer  = lay_rd;
      end
      default: ;
    endcase
  end

  // output register: hold until taken, load when free or draining
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_d             = res_q;
    out_d.any_visible = |(valid_q & vis_q);
  end

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      valid_q     <= '0;
      vis_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      vis_q       <= vis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i.payload;
    end
    res_q  <= res_d;
    best_q <= best_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTH
  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted beat did not start execution");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= LastCnt))
    else $error("scan index ran past the table");

  a_done_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_valid_q && !rsp_o.ready) |=> (state_q == ST_DONE))
    else $error("result left the sequencer while the output register was full");

  a_id_implies_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.payload.result_id != '0)) |-> rsp_o.payload.success)
    else $error("non-zero result id without success");
`endif

endmodule

>>> rtl/wth_ram.sv
// ----------------------------------------------------------------------------
// wth_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wth_ram #(
  parameter int Width = 16,
  parameter int Depth = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/tb_window_table_hit_test_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_window_table_hit_test_top
// Drives window table actions into the block and checks every response beat
// against a behavioural copy of the table or a fixed result. A short
// directed table comes first, then a random mix of well-formed action
// streams and noise, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_window_table_hit_test_top;
  import wth_pkg::*;

  localparam int RandomItems = 500;
  localparam int QuietLimit  = 5000;
  localparam int DrainCycles = 40;

  localparam logic [3:0] ActUnusedFirst = 4'd9;
  localparam logic [3:0] ActUnusedLast  = 4'd15;
  localparam logic [15:0] CoordMax      = 16'hFFFF;
  localparam rsp_t NoResult             = '0;

  typedef struct {
    req_t action;
    bit   typed;
    rsp_t result;
  } stim_row_t;

  logic clk;
  logic rst_n;

  wth_req_if req_if ();
  wth_rsp_if rsp_if ();

  window_table_hit_test_top #(
    .MaxWindows(MAX_WINDOWS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the window table
  logic        win_valid   [MAX_WINDOWS];
  logic        win_visible [MAX_WINDOWS];
  logic [15:0] win_left    [MAX_WINDOWS];
  logic [15:0] win_top     [MAX_WINDOWS];
  logic [15:0] win_wide    [MAX_WINDOWS];
  logic [15:0] win_tall    [MAX_WINDOWS];
  logic [15:0] win_layer   [MAX_WINDOWS];

  rsp_t        window_results [$];
  stim_row_t   directed_rows  [$];
  int          errors;
  int          burst_left;
  int unsigned quiet_cycles;
  int unsigned rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_tick;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------
  function automatic rsp_t apply_window_action(input req_t r);
    rsp_t res;
    int   id;
    int   slot;
    int   free_slot;
    bit   found;
    logic [15:0] best;
    res       = '0;
    id        = int'(r.window_id);
    slot      = -1;
    free_slot = -1;
    found     = 1'b0;
    best      = '0;
    if (id != 0 && id <= MAX_WINDOWS && win_valid[id-1]) slot = id - 1;
    case (r.action)
      ACT_CREATE: begin
        for (int i = 0; i < MAX_WINDOWS; i++)
          if (!win_valid[i] && free_slot < 0) free_slot = i;
        if (r.width != 0 && r.height != 0 && free_slot >= 0) begin
          win_valid[free_slot]   = 1'b1;
          win_visible[free_slot] = 1'b1;
          win_left[free_slot]    = r.pos_x;
          win_top[free_slot]     = r.pos_y;
          win_wide[free_slot]    = r.width;
          win_tall[free_slot]    = r.height;
          win_layer[free_slot]   = r.layer;
          res.result_id          = ID_W'(free_slot + 1);
          res.success            = 1'b1;
        end
      end
      ACT_DESTROY: if (slot >= 0) begin
        win_valid[slot]   = 1'b0;
        win_visible[slot] = 1'b0;
        win_left[slot]    = '0;
        win_top[slot]     = '0;
        win_wide[slot]    = '0;
        win_tall[slot]    = '0;
        win_layer[slot]   = '0;
        res.success       = 1'b1;
      end
      ACT_SHOW: if (slot >= 0) begin
        win_visible[slot] = 1'b1;
        res.success       = 1'b1;
      end
      ACT_HIDE: if (slot >= 0) begin
        win_visible[slot] = 1'b0;
        res.success       = 1'b1;
      end
      ACT_MOVE: if (slot >= 0) begin
        win_left[slot] = r.pos_x;
        win_top[slot]  = r.pos_y;
        res.success    = 1'b1;
      end
      ACT_SET_LAYER: if (slot >= 0) begin
        win_layer[slot] = r.layer;
        res.success     = 1'b1;
      end
      ACT_HIT_TEST: begin
        // edges summed without wrap; later slot wins a tie
        for (int i = 0; i < MAX_WINDOWS; i++) begin
          if (win_valid[i] && win_visible[i] &&
              r.pos_x >= win_left[i] &&
              int'(r.pos_x) < int'(win_left[i]) + int'(win_wide[i]) &&
              r.pos_y >= win_top[i] &&
              int'(r.pos_y) < int'(win_top[i]) + int'(win_tall[i]) &&
              (!found || win_layer[i] >= best)) begin
            found         = 1'b1;
            best          = win_layer[i];
            res.result_id = ID_W'(i + 1);
          end
        end
        res.success = found;
      end
      ACT_QUERY: if (slot >= 0) begin
        res.success    = 1'b1;
        res.out_x      = win_left[slot];
        res.out_y      = win_top[slot];
        res.out_width  = win_wide[slot];
        res.out_height = win_tall[slot];
        res.out_layer  = win_layer[slot];
      end
      ACT_TOP_LAYER: begin
        for (int i = 0; i < MAX_WINDOWS; i++) begin
          if (win_valid[i] && win_visible[i] &&
              (!res.success || win_layer[i] > res.out_layer)) begin
            res.out_layer = win_layer[i];
            res.success   = 1'b1;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < MAX_WINDOWS; i++)
      if (win_valid[i] && win_visible[i]) res.any_visible = 1'b1;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic req_t make_action(input logic [3:0] act, input int id,
                                       input int px, input int py, input int w,
                                       input int h, input int z);
    req_t r;
    r.action    = act;
    r.window_id = ID_W'(id);
    r.pos_x     = COORD_W'(px);
    r.pos_y     = COORD_W'(py);
    r.width     = COORD_W'(w);
    r.height    = COORD_W'(h);
    r.layer     = COORD_W'(z);
    return r;
  endfunction

  function automatic rsp_t make_result(input int rid, input bit ok, input int ox,
                                       input int oy, input int ow, input int oh,
                                       input int ol, input bit anyv);
    rsp_t e;
    e.result_id   = ID_W'(rid);
    e.success     = ok;
    e.out_x       = COORD_W'(ox);
    e.out_y       = COORD_W'(oy);
    e.out_width   = COORD_W'(ow);
    e.out_height  = COORD_W'(oh);
    e.out_layer   = COORD_W'(ol);
    e.any_visible = anyv;
    return e;
  endfunction

  function automatic logic [15:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return COORD_W'($urandom);
    if (pick == 1) return $urandom_range(0, 1) ? CoordMax : '0;
    return COORD_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] random_size();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick < 3) return COORD_W'($urandom);
    return COORD_W'($urandom_range(1, 96));
  endfunction

  function automatic logic [15:0] random_layer();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return COORD_W'($urandom_range(0, 7));
    if (pick < 9) return COORD_W'($urandom);
    return $urandom_range(0, 1) ? CoordMax : '0;
  endfunction

  // Mostly live-table actions on ids in range, with some noise mixed in
  function automatic req_t random_action();
    req_t        r;
    int unsigned roll;
    int          s;
    int          px;
    int          py;
    r.window_id = ($urandom_range(0, 99) < 85) ? ID_W'($urandom_range(1, MAX_WINDOWS))
                                               : ID_W'($urandom_range(0, 15));
    r.pos_x  = random_coord();
    r.pos_y  = random_coord();
    r.width  = random_size();
    r.height = random_size();
    r.layer  = random_layer();
    roll = $urandom_range(0, 99);
    if      (roll < 16) r.action = ACT_CREATE;
    else if (roll < 24) r.action = ACT_DESTROY;
    else if (roll < 30) r.action = ACT_SHOW;
    else if (roll < 37) r.action = ACT_HIDE;
    else if (roll < 44) r.action = ACT_MOVE;
    else if (roll < 51) r.action = ACT_SET_LAYER;
    else if (roll < 76) r.action = ACT_HIT_TEST;
    else if (roll < 86) r.action = ACT_QUERY;
    else if (roll < 95) r.action = ACT_TOP_LAYER;
    else r.action = 4'($urandom_range(ActUnusedFirst, ActUnusedLast));
    if (r.action == ACT_HIT_TEST) begin
      // aim inside the picked window half the time when it is live
      s = $urandom_range(0, MAX_WINDOWS - 1);
      if (win_valid[s] && $urandom_range(0, 1)) begin
        px = int'(win_left[s]) + int'($urandom_range(0, int'(win_wide[s]) - 1));
        py = int'(win_top[s]) + int'($urandom_range(0, int'(win_tall[s]) - 1));
        r.pos_x = (px > int'(CoordMax)) ? CoordMax : COORD_W'(px);
        r.pos_y = (py > int'(CoordMax)) ? CoordMax : COORD_W'(py);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: called and returns at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_action(input req_t item, input bit typed, input rsp_t typed_rsp);
    rsp_t predicted;
    req_if.payload <= item;
    req_if.valid   <= 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = apply_window_action(item);
    window_results.push_back(typed ? typed_rsp : predicted);
    @(negedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_table_quiet();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (window_results.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      0:       rsp_if.ready <= 1'b1;
      1:       rsp_if.ready <= ($urandom_range(0, 1) == 0);
      2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_if.ready <= (rx_tick % 7) > 2;
    endcase
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(input rsp_t want, input rsp_t got);
    check_field("result_id",   want.result_id,   got.result_id);
    check_field("success",     want.success,     got.success);
    check_field("out_x",       want.out_x,       got.out_x);
    check_field("out_y",       want.out_y,       got.out_y);
    check_field("out_width",   want.out_width,   got.out_width);
    check_field("out_height",  want.out_height,  got.out_height);
    check_field("out_layer",   want.out_layer,   got.out_layer);
    check_field("any_visible", want.any_visible, got.any_visible);
  endfunction

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (window_results.size() == 0) begin
        $error("response beat with no action outstanding");
        errors++;
      end else begin
        check_result(window_results.pop_front(), rsp_if.payload);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles with no beat on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("tb_window_table_hit_test_top: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    errors         = 0;
    burst_left     = 0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      win_valid[i]   = 1'b0;
      win_visible[i] = 1'b0;
      win_left[i]    = '0;
      win_top[i]     = '0;
      win_wide[i]    = '0;
      win_tall[i]    = '0;
      win_layer[i]   = '0;
    end

    // empty table
    directed_rows.push_back('{make_action(ACT_TOP_LAYER, 0, 0, 0, 0, 0, 0), 1'b1,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_HIT_TEST, 1, 0, 0, 0, 0, 0), 1'b1,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_DESTROY, 0, 0, 0, 0, 0, 0), 1'b1,
                              NoResult});
    // zero width, zero height
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 3, 3, 0, 5, 1), 1'b1,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 3, 3, 5, 0, 1), 1'b1,
                              NoResult});
    // extremes: full-screen window, one-pixel window in the far corner
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 0, 0, 65535, 65535, 0), 1'b1,
                              make_result(1, 1'b1, 0, 0, 0, 0, 0, 1'b1)});
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 65535, 65535, 1, 1, 65535),
                              1'b1, make_result(2, 1'b1, 0, 0, 0, 0, 0, 1'b1)});
    directed_rows.push_back('{make_action(ACT_HIT_TEST, 0, 65535, 65535, 0, 0, 0), 1'b0,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_HIT_TEST, 0, 65534, 65534, 0, 0, 0), 1'b0,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_QUERY, 2, 0, 0, 0, 0, 0), 1'b1,
                              make_result(0, 1'b1, 65535, 65535, 1, 1, 65535, 1'b1)});
    // fill the table; ids 3 and 4 overlap on equal layers
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 10, 10, 20, 20, 5), 1'b0,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 15, 15, 20, 20, 5), 1'b0,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 100, 100, 8, 8, 3), 1'b0,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 200, 0, 50, 50, 7), 1'b0,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 0, 200, 1, 1, 1), 1'b0,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 300, 300, 10, 10, 2), 1'b0,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_CREATE, 0, 1, 1, 1, 1, 1), 1'b1,
                              make_result(0, 1'b0, 0, 0, 0, 0, 0, 1'b1)});
    directed_rows.push_back('{make_action(ACT_HIT_TEST, 0, 20, 20, 0, 0, 0), 1'b0,
                              NoResult});
    // ids out of range and unused action codes
    directed_rows.push_back('{make_action(ACT_SHOW, MAX_WINDOWS + 1, 0, 0, 0, 0, 0), 1'b1,
                              make_result(0, 1'b0, 0, 0, 0, 0, 0, 1'b1)});
    directed_rows.push_back('{make_action(ACT_DESTROY, 15, 0, 0, 0, 0, 0), 1'b1,
                              make_result(0, 1'b0, 0, 0, 0, 0, 0, 1'b1)});
    directed_rows.push_back('{make_action(ActUnusedFirst, 1, 9, 9, 9, 9, 9), 1'b1,
                              make_result(0, 1'b0, 0, 0, 0, 0, 0, 1'b1)});
    directed_rows.push_back('{make_action(ActUnusedLast, 15, 65535, 65535, 65535, 65535,
                                          65535), 1'b1,
                              make_result(0, 1'b0, 0, 0, 0, 0, 0, 1'b1)});
    // change state, then look again
    directed_rows.push_back('{make_action(ACT_HIDE, 2, 0, 0, 0, 0, 0), 1'b0, NoResult});
    directed_rows.push_back('{make_action(ACT_SET_LAYER, 3, 0, 0, 0, 0, 65535), 1'b0,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_MOVE, 4, 65535, 0, 0, 0, 0), 1'b0, NoResult});
    directed_rows.push_back('{make_action(ACT_TOP_LAYER, 0, 0, 0, 0, 0, 0), 1'b0,
                              NoResult});
    directed_rows.push_back('{make_action(ACT_DESTROY, 2, 0, 0, 0, 0, 0), 1'b0, NoResult});
    directed_rows.push_back('{make_action(ACT_QUERY, 2, 0, 0, 0, 0, 0), 1'b1,
                              make_result(0, 1'b0, 0, 0, 0, 0, 0, 1'b1)});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_action(row.action, row.typed, row.result);
      pace_sender();
    end

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) wait_table_quiet();
      send_action(random_action(), 1'b0, NoResult);
      pace_sender();
    end
    req_if.valid <= 1'b0;

    while (window_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0) begin
      $display("tb_window_table_hit_test_top: PASS");
    end else begin
      $display("tb_window_table_hit_test_top: FAIL");
    end
    $finish;
  end

endmodule
